[rtl/core/vsa_pkg.sv]
// ============================================================================
// vsa_pkg
// Shared types and constants for the versioned snapshot array: request and
// result formats, operation and status codes, memory geometry and the write
// port structs that connect the controller to its memories.
// ============================================================================
package vsa_pkg;

    // Array geometry.
    localparam int ENTRIES     = 1024;
    localparam int RECORDS     = 16;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int SLOT_W      = $clog2(RECORDS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int REC_ADDR_W  = IDX_W + SLOT_W;
    localparam int BIT_W       = $clog2(SLOT_W + 1);
    localparam int LEN_W       = 11;
    localparam int SNAP_W      = 16;
    localparam int VAL_W       = 32;

    // Configuration port.
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam logic [0:0] REG_ACTIVE_LENGTH = 1'b0;
    localparam logic [LEN_W-1:0] ACTIVE_LENGTH_RESET = LEN_W'(ENTRIES);

    // Saturation point of the snapshot counter.
    localparam logic [SNAP_W-1:0] SNAP_MAX = '1;

    // Operation codes.
    localparam logic [1:0] MODE_SET  = 2'd0;
    localparam logic [1:0] MODE_SNAP = 2'd1;
    localparam logic [1:0] MODE_GET  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [IDX_W-1:0]  entry_index;
        logic [VAL_W-1:0]  write_value;
        logic [SNAP_W-1:0] query_snap;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic [SNAP_W-1:0] snap_number;
        logic [1:0]        status;
    } t_res;

    // One history record.
    typedef struct packed {
        logic [SNAP_W-1:0] snap;
        logic [VAL_W-1:0]  value;
    } t_record;

    // Write port of the record count memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [CNT_W-1:0] data;
    } t_cnt_wr;

    // Write port of the record memory.
    typedef struct packed {
        logic                  we;
        logic [REC_ADDR_W-1:0] addr;
        t_record               data;
    } t_rec_wr;

endpackage

[rtl/core/vsa_cfg.sv]
// ============================================================================
// vsa_cfg
// APB-style register slave holding the active length register.
// ============================================================================
module vsa_cfg
    import vsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LEN_W-1:0]      o_active_length
);

    logic [LEN_W-1:0] r_active_length;
    logic [0:0]       reg_sel;

    // Registers sit on 32-bit word boundaries.
    assign reg_sel = paddr[2:2];
    assign pready  = 1'b1;

    // Register write on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_length <= ACTIVE_LENGTH_RESET;
        end else if (psel && penable && pwrite && reg_sel == REG_ACTIVE_LENGTH) begin
            r_active_length <= pwdata[LEN_W-1:0];
        end
    end

    // Read back.
    always_comb begin
        prdata = '0;
        if (reg_sel == REG_ACTIVE_LENGTH) begin
            prdata = CFG_DATA_W'(r_active_length);
        end
    end

    assign o_active_length = r_active_length;

endmodule

[rtl/core/vsa_count_store.sv]
// ============================================================================
// vsa_count_store
// Per-entry record count memory with a clearing sweep after reset.
// ============================================================================
module vsa_count_store
    import vsa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_addr,
    input  t_cnt_wr          i_wr,
    output logic [CNT_W-1:0] o_rd_data,
    output logic             o_ready
);

    logic [CNT_W-1:0] mem [ENTRIES];
    logic [CNT_W-1:0] r_rd_data;
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;

    // Clearing sweep: one entry per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == IDX_W'(ENTRIES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // The sweep owns the write port until it is done.
    always_comb begin
        wr_en   = i_wr.we;
        wr_addr = i_wr.addr;
        wr_data = i_wr.data;
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end
    end

    // Memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clearing;

endmodule

[rtl/core/vsa_record_store.sv]
// ============================================================================
// vsa_record_store
// History record memory: snapshot number and value for each slot of each
// entry, one write and one read port, read data registered.
// ============================================================================
module vsa_record_store
    import vsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic [REC_ADDR_W-1:0] i_rd_addr,
    input  t_rec_wr               i_wr,
    output t_record               o_rd_data
);

    t_record mem [ENTRIES * RECORDS];
    t_record r_rd_data;

    // Memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/vsa_engine.sv]
// ============================================================================
// vsa_engine
// Request controller: decodes each request, reads the record count, runs the
// set read-modify-write or the binary search for a get, keeps the snapshot
// counter and registers the result.
// ============================================================================
module vsa_engine
    import vsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_req                  i_req,
    input  logic [LEN_W-1:0]      i_active_length,
    input  logic                  i_cnt_ready,
    input  logic [CNT_W-1:0]      i_cnt_rd_data,
    input  t_record               i_rec_rd_data,
    output logic [IDX_W-1:0]      o_cnt_rd_addr,
    output t_cnt_wr               o_cnt_wr,
    output logic [REC_ADDR_W-1:0] o_rec_rd_addr,
    output t_rec_wr               o_rec_wr,
    output logic                  o_busy,
    output logic                  o_res_valid,
    output t_res                  o_res
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOK   = 4'b0010,
        S_SETCHK = 4'b0100,
        S_SEARCH = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    t_req              r_req;
    logic [SNAP_W-1:0] r_snap_cnt, n_snap_cnt;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_probe, n_probe;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [VAL_W-1:0]  r_val, n_val;
    logic              r_res_valid, n_res_valid;
    t_res              r_res, n_res;

    logic              accept;
    logic              in_range;
    logic              probe_ok;
    logic [CNT_W-1:0]  n_found;
    logic [CNT_W-1:0]  probe_first;
    logic [CNT_W-1:0]  probe_next;
    logic [CNT_W-1:0]  slot_pick;
    logic [CNT_W-1:0]  cnt_last;

    assign o_busy = (r_state != S_IDLE) || !i_cnt_ready;
    assign accept = i_start && !o_busy;

    // The count read follows the request being worked on.
    assign o_cnt_rd_addr = (r_state == S_IDLE) ? i_req.entry_index : r_req.entry_index;

    // Index check; a length above the array size covers every index.
    assign in_range = {1'b0, r_req.entry_index} < i_active_length;

    // Search probes: the first probe covers the whole history.
    assign cnt_last    = i_cnt_rd_data - 1'b1;
    assign probe_first = CNT_W'(1) << SLOT_W;
    assign probe_ok    = (r_probe <= i_cnt_rd_data)
                      && (i_rec_rd_data.snap <= r_req.query_snap);
    assign n_found     = probe_ok ? r_probe : r_n;
    assign probe_next  = n_found + (CNT_W'(1) << (r_bit - 1'b1));

    // Record read address.
    always_comb begin
        slot_pick = cnt_last;
        if (r_state == S_LOOK && r_req.mode == MODE_GET) begin
            slot_pick = probe_first - 1'b1;
        end else if (r_state == S_SEARCH) begin
            slot_pick = probe_next - 1'b1;
        end
    end
    assign o_rec_rd_addr = {r_req.entry_index, slot_pick[SLOT_W-1:0]};

    // Next-state logic.
    always_comb begin
        n_state     = r_state;
        n_snap_cnt  = r_snap_cnt;
        n_n         = r_n;
        n_probe     = r_probe;
        n_bit       = r_bit;
        n_val       = r_val;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_cnt_wr    = '0;
        o_rec_wr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end

            S_LOOK: begin
                n_res   = '0;
                n_n     = '0;
                n_val   = '0;
                n_probe = probe_first;
                n_bit   = BIT_W'(SLOT_W);
                unique case (r_req.mode)
                    MODE_SET, MODE_GET: begin
                        if (!in_range) begin
                            n_res.status = ST_RANGE;
                            n_res_valid  = 1'b1;
                            n_state      = S_IDLE;
                        end else if (r_req.mode == MODE_SET) begin
                            n_state = S_SETCHK;
                        end else begin
                            n_state = S_SEARCH;
                        end
                    end
                    MODE_SNAP: begin
                        if (r_snap_cnt >= SNAP_MAX) begin
                            n_res.status = ST_SAT;
                        end else begin
                            n_res.snap_number = r_snap_cnt;
                            n_snap_cnt        = r_snap_cnt + 1'b1;
                        end
                        n_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                    default: begin
                        n_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                endcase
            end

            // Newest record is in hand: overwrite, append or report full.
            S_SETCHK: begin
                n_res = '0;
                if (i_cnt_rd_data != '0 && i_rec_rd_data.snap == r_snap_cnt) begin
                    o_rec_wr.we   = 1'b1;
                    o_rec_wr.addr = {r_req.entry_index, cnt_last[SLOT_W-1:0]};
                end else if (i_cnt_rd_data >= CNT_W'(RECORDS)) begin
                    n_res.status = ST_FULL;
                end else begin
                    o_rec_wr.we   = 1'b1;
                    o_rec_wr.addr = {r_req.entry_index, i_cnt_rd_data[SLOT_W-1:0]};
                    o_cnt_wr.we   = 1'b1;
                    o_cnt_wr.addr = r_req.entry_index;
                    o_cnt_wr.data = i_cnt_rd_data + 1'b1;
                end
                o_rec_wr.data.snap  = r_snap_cnt;
                o_rec_wr.data.value = r_req.write_value;
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end

            // One bit of the matching record count per step.
            S_SEARCH: begin
                n_n = n_found;
                if (probe_ok) begin
                    n_val = i_rec_rd_data.value;
                end
                if (r_bit == '0) begin
                    n_res            = '0;
                    n_res.read_value = probe_ok ? i_rec_rd_data.value : r_val;
                    n_res_valid      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_probe = probe_next;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_snap_cnt  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_snap_cnt  <= n_snap_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        r_n     <= n_n;
        r_probe <= n_probe;
        r_bit   <= n_bit;
        r_val   <= n_val;
        r_res   <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

[rtl/core/versioned_snapshot_array.sv]
// ============================================================================
// versioned_snapshot_array
// Versioned array with per-entry history, snapshot counter and point-in-time
// reads; top level joining the register port, controller and memories.
// ============================================================================
// Usage:
// A request (mode, entry index, write value, query snapshot) is taken at a
// rising edge where start is high and busy is low. Every request yields one
// result (read value, snapshot number, status), shown for exactly one cycle
// with o_res_valid high; the receiver must take it then.
// Snap and undefined modes and an out-of-range set or get finish in the
// look-up state; a set runs count read, newest record read, write back; a
// get runs a count read, then a binary search of one dependent record memory
// read per step, five steps for sixteen records. busy drops in the result
// cycle, so the next request may be taken at its closing edge.
// Reset clears the snapshot counter and the control state, then the record
// count memory is swept clear, one entry per cycle, with busy held high. The
// register port accepts writes throughout; the user must write active_length
// only while no request is in flight, as the block does not enforce this.
// ============================================================================
module versioned_snapshot_array
    import vsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_req                  i_req,
    output logic                  o_res_valid,
    output t_res                  o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [LEN_W-1:0]      active_length;
    logic [IDX_W-1:0]      cnt_rd_addr;
    logic [CNT_W-1:0]      cnt_rd_data;
    logic                  cnt_ready;
    t_cnt_wr               cnt_wr;
    logic [REC_ADDR_W-1:0] rec_rd_addr;
    t_record               rec_rd_data;
    t_rec_wr               rec_wr;

    // Configuration registers.
    vsa_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_active_length (active_length)
    );

    // Record counts per entry.
    vsa_count_store u_count (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (cnt_rd_addr),
        .i_wr      (cnt_wr),
        .o_rd_data (cnt_rd_data),
        .o_ready   (cnt_ready)
    );

    // History records.
    vsa_record_store u_record (
        .i_clk     (i_clk),
        .i_rd_addr (rec_rd_addr),
        .i_wr      (rec_wr),
        .o_rd_data (rec_rd_data)
    );

    // Request controller.
    vsa_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_req           (i_req),
        .i_active_length (active_length),
        .i_cnt_ready     (cnt_ready),
        .i_cnt_rd_data   (cnt_rd_data),
        .i_rec_rd_data   (rec_rd_data),
        .o_cnt_rd_addr   (cnt_rd_addr),
        .o_cnt_wr        (cnt_wr),
        .o_rec_rd_addr   (rec_rd_addr),
        .o_rec_wr        (rec_wr),
        .o_busy          (busy),
        .o_res_valid     (o_res_valid),
        .o_res           (o_res)
    );

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the versioned snapshot array. Requests are issued
// through the start/busy handshake in random bursts, and a predictor keeps
// its own copy of the entry histories, the snapshot counter and the active
// length, so every result is checked field by field in request order.
// Directed tests cover the extremes and special cases. Random phases run
// under several active lengths. A final test issues a gapless run of snaps
// and then works at the newest snapshot.
// ============================================================================
module testbench;
    import vsa_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] LENGTH_ADDR = CFG_ADDR_W'(4 * REG_ACTIVE_LENGTH);
    localparam logic [1:0] MODE_UNDEF = 2'd3;
    localparam int HOT_COUNT = 6;
    localparam int SETTLE_CYCLES = 10;
    localparam int SNAP_RUN = 40;

    // Block ports; the inputs are all known from time zero.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_req = '0;
    logic                  o_res_valid;
    t_res                  o_res;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Predicted state of the array.
    logic [VAL_W-1:0]  hist_value [ENTRIES][RECORDS];
    logic [SNAP_W-1:0] hist_snap [ENTRIES][RECORDS];
    int                hist_count [ENTRIES];
    logic [SNAP_W-1:0] cur_snap = '0;
    logic [LEN_W-1:0]  len_reg = ACTIVE_LENGTH_RESET;

    // Results owed by the block, oldest first.
    t_res pending_results [$];
    t_res want;
    int   failures = 0;

    // Sender pacing and the entries that random traffic keeps returning to.
    int               burst_left = 0;
    bit               pacing_on = 1'b1;
    logic [IDX_W-1:0] hot_entries [HOT_COUNT];

    versioned_snapshot_array dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Indices at or above this count are out of range.
    function automatic int effective_length();
        return (int'(len_reg) > ENTRIES) ? ENTRIES : int'(len_reg);
    endfunction

    // Applies one request to the predicted state and returns its result.
    function automatic t_res apply_request(t_req r);
        t_res res;
        int   idx;
        int   cnt;
        int   k;
        res = '0;
        idx = int'(r.entry_index);
        case (r.mode)
            MODE_SET: begin
                if (idx >= effective_length()) begin
                    res.status = ST_RANGE;
                end else begin
                    cnt = hist_count[idx];
                    // A set under the newest record's snapshot rewrites it in place.
                    if (cnt > 0 && hist_snap[idx][cnt-1] == cur_snap) begin
                        hist_value[idx][cnt-1] = r.write_value;
                    end else if (cnt >= RECORDS) begin
                        res.status = ST_FULL;
                    end else begin
                        hist_snap[idx][cnt] = cur_snap;
                        hist_value[idx][cnt] = r.write_value;
                        hist_count[idx] = cnt + 1;
                    end
                end
            end
            MODE_SNAP: begin
                if (cur_snap == SNAP_MAX) begin
                    res.status = ST_SAT;
                end else begin
                    res.snap_number = cur_snap;
                    cur_snap = cur_snap + 1'b1;
                end
            end
            MODE_GET: begin
                if (idx >= effective_length()) begin
                    res.status = ST_RANGE;
                end else begin
                    cnt = hist_count[idx];
                    // Snapshot numbers never decrease along a history.
                    for (k = 0; k < cnt && hist_snap[idx][k] <= r.query_snap; k++)
                        res.read_value = hist_value[idx][k];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Each result must match the oldest request still waiting.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending");
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (o_res.read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value, o_res.read_value);
                    failures++;
                end
                if (o_res.snap_number !== want.snap_number) begin
                    $error("snap_number: expected %h, got %h",
                           want.snap_number, o_res.snap_number);
                    failures++;
                end
                if (o_res.status !== want.status) begin
                    $error("status: expected %h, got %h", want.status, o_res.status);
                    failures++;
                end
            end
        end
    end

    function automatic t_req make_req(logic [1:0] mode, logic [IDX_W-1:0] index,
                                      logic [VAL_W-1:0] value, logic [SNAP_W-1:0] query);
        t_req r;
        r.mode = mode;
        r.entry_index = index;
        r.write_value = value;
        r.query_snap = query;
        return r;
    endfunction

    // Ends a burst now and then with a random gap on the request side.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // Holds the request until the block takes it, then records the prediction.
    task automatic issue_request(input t_req r);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.insert(pending_results.size(), apply_request(r));
        if (pacing_on)
            pace();
    endtask

    // Drains every outstanding result so that the register may be written.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes active_length, then reads it back in a second transfer.
    task automatic set_length(input logic [LEN_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LENGTH_ADDR;
        pwdata <= CFG_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        len_reg = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[LEN_W-1:0] !== len_reg) begin
            $error("active_length: expected %h, got %h", len_reg, prdata[LEN_W-1:0]);
            failures++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reads the reset value, then writes the register back to full length.
    task automatic test_register_reset();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= LENGTH_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[LEN_W-1:0] !== ACTIVE_LENGTH_RESET) begin
            $error("active_length: expected %h, got %h",
                   ACTIVE_LENGTH_RESET, prdata[LEN_W-1:0]);
            failures++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        set_length(ACTIVE_LENGTH_RESET);
    endtask

    // Empty entries, overwrite under one snapshot, history lookups and the
    // undefined mode.
    task automatic test_history_basics();
        issue_request(make_req(MODE_GET, '0, '0, '0));
        issue_request(make_req(MODE_SET, '0, '1, '0));
        issue_request(make_req(MODE_SET, '0, 32'h1234_5678, '1));
        issue_request(make_req(MODE_GET, '0, '1, '0));
        issue_request(make_req(MODE_SNAP, '1, '1, '1));
        issue_request(make_req(MODE_GET, '0, '0, '1));
        issue_request(make_req(MODE_SET, '1, '1, '0));
        issue_request(make_req(MODE_SET, '0, 32'hA5A5_A5A5, '0));
        issue_request(make_req(MODE_GET, '0, '0, '0));
        issue_request(make_req(MODE_GET, '0, '0, 16'd1));
        issue_request(make_req(MODE_GET, '1, '0, '0));
        issue_request(make_req(MODE_GET, '1, '0, '1));
        issue_request(make_req(MODE_UNDEF, '1, '1, '1));
        issue_request(make_req(MODE_SNAP, '0, '0, '0));
    endtask

    // Out-of-range indices at the length extremes.
    task automatic test_index_range();
        wait_idle();
        set_length(LEN_W'(1));
        issue_request(make_req(MODE_SET, 10'd1, 32'hDEAD_BEEF, '0));
        issue_request(make_req(MODE_GET, 10'd1, '0, '1));
        issue_request(make_req(MODE_GET, '1, '0, '1));
        issue_request(make_req(MODE_GET, '0, '0, '1));
        wait_idle();
        set_length('0);
        issue_request(make_req(MODE_SET, '0, 32'h0BAD_F00D, '0));
        issue_request(make_req(MODE_GET, '0, '0, '1));
        wait_idle();
        set_length('1);
        issue_request(make_req(MODE_SET, '1, 32'h5A5A_5A5A, '0));
        issue_request(make_req(MODE_GET, '1, '0, '1));
    endtask

    // Random request mostly aimed at a few hot entries so histories fill up.
    function automatic t_req random_request();
        t_req r;
        int   eff;
        int   pick;
        eff = effective_length();
        r.write_value = $urandom();
        r.query_snap = SNAP_W'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.mode = MODE_SET;
        else if (pick < 60)
            r.mode = MODE_SNAP;
        else if (pick < 95)
            r.mode = MODE_GET;
        else
            r.mode = MODE_UNDEF;
        pick = $urandom_range(0, 99);
        if (pick < 70 && eff > 0)
            r.entry_index = hot_entries[$urandom_range(0, HOT_COUNT - 1)];
        else if (pick < 90 && eff > 0)
            r.entry_index = IDX_W'($urandom_range(0, eff - 1));
        else
            r.entry_index = IDX_W'($urandom());
        // Most queries land near the snapshots that actually exist.
        if ($urandom_range(0, 9) < 7)
            r.query_snap = SNAP_W'($urandom_range(0, int'(cur_snap) + 2));
        return r;
    endfunction

    // One phase of random traffic under a given active length.
    task automatic test_random_traffic(input int count, input logic [LEN_W-1:0] length);
        int eff;
        wait_idle();
        set_length(length);
        eff = effective_length();
        hot_entries[0] = '0;
        hot_entries[1] = (eff > 0) ? IDX_W'(eff - 1) : '0;
        for (int i = 2; i < HOT_COUNT; i++)
            hot_entries[i] = (eff > 0) ? IDX_W'($urandom_range(0, eff - 1)) : '0;
        repeat (count) issue_request(random_request());
    endtask

    // Runs a string of snaps with no gaps, then works at the newest snapshot.
    task automatic test_snapshot_run();
        wait_idle();
        set_length(ACTIVE_LENGTH_RESET);
        pacing_on = 1'b0;
        repeat (SNAP_RUN)
            issue_request(make_req(MODE_SNAP, IDX_W'($urandom()), $urandom(), '0));
        pacing_on = 1'b1;
        issue_request(make_req(MODE_SET, 10'd7, 32'hCAFE_0001, '0));
        issue_request(make_req(MODE_SET, 10'd7, 32'hCAFE_0002, '0));
        issue_request(make_req(MODE_GET, 10'd7, '0, '1));
        issue_request(make_req(MODE_GET, 10'd7, '0, cur_snap - 1'b1));
        issue_request(make_req(MODE_SNAP, '1, '1, '1));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(0, 10);
        test_register_reset();
        test_history_basics();
        test_index_range();
        test_random_traffic(300, ACTIVE_LENGTH_RESET);
        test_random_traffic(300, LEN_W'($urandom_range(2, ENTRIES - 1)));
        test_random_traffic(150, LEN_W'(1));
        test_random_traffic(50, '0);
        test_random_traffic(300, '1);
        test_random_traffic(300, ACTIVE_LENGTH_RESET);
        test_snapshot_run();
        wait_idle();
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
